/* rtl/bf16_dot_product_with_safety_screen_macros.svh */
// Assertion macros used by the checker file of the dot product block.
`ifndef BF16_DOT_PRODUCT_WITH_SAFETY_SCREEN_MACROS_SVH
`define BF16_DOT_PRODUCT_WITH_SAFETY_SCREEN_MACROS_SVH

// A clocked property that is switched off while reset is asserted.
`define BDP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A same-cycle implication built on the macro above.
`define BDP_IMPLIES(label, ante, cons, msg) \
	`BDP_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/bdp_pkg.sv */
package bdp_pkg;

	localparam int LANES  = 16;
	localparam int LANE_W = 4;

	localparam logic [14:0] SUBNORM_LIMIT = 15'h0080;
	localparam logic [14:0] FINITE_LIMIT  = 15'h7F7F;
	localparam logic [9:0]  OVF_BOUND     = 10'd380;
	localparam logic [30:0] RANGE_LIMIT   = 31'h0F80_0000;
	localparam logic [31:0] QNAN          = 32'h7FC0_0000;
	localparam logic [31:0] RNE_BIAS      = 32'h0000_7FFF;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_UNSAFE   = 2'd1,
		CAUSE_OVERFLOW = 2'd2,
		CAUSE_RANGE    = 2'd3
	} cause_t;

	typedef struct packed {
		logic [15:0] x_even;
		logic [15:0] x_odd;
		logic [15:0] w_even;
		logic [15:0] w_odd;
		logic [1:0]  real_count;
		logic        last_pair;
	} item_t;

	typedef struct packed {
		logic [15:0] result_code;
		logic        native_ok;
		logic [1:0]  fallback_cause;
	} result_t;

	// Screen outcome known by the front once the last pair is taken.
	typedef struct packed {
		logic unsafe;
		logic ovf;
	} flags_t;

	// Per-pair control carried down the lane pipeline.
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic              wrapped;
		logic              last;
		flags_t            flags;
	} meta_t;

	// Classified pair as queued between front and back.
	typedef struct packed {
		logic [15:0] xe;
		logic [15:0] xo;
		logic [15:0] we;
		logic [15:0] wo;
		meta_t       meta;
	} entry_t;

	// Result of the alignment half of the FP32 adder.
	typedef struct packed {
		logic        special;
		logic [31:0] spec_val;
		logic        sign;
		logic        zsign;
		logic [9:0]  exp;
		logic [27:0] mant;
	} align_t;

	// Subnormal values become zero of the same sign.
	function automatic logic [31:0] flush32(input logic [31:0] v);
		logic [31:0] r;
		r = v;
		if (v[30:23] == 8'h00) begin
			r = {v[31], 31'b0};
		end
		return r;
	endfunction

	// Exact product of two BF16 codes as FP32, subnormal inputs taken as zero.
	function automatic logic [31:0] bf16_mul(input logic [15:0] a, input logic [15:0] b);
		logic               s;
		logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
		logic [15:0]        p;
		logic signed [10:0] e;
		logic [22:0]        frac;
		logic [31:0]        r;
		s      = a[15] ^ b[15];
		a_zero = (a[14:7] == 8'h00);
		b_zero = (b[14:7] == 8'h00);
		a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'h00);
		b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'h00);
		a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'h00);
		b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'h00);
		p      = {1'b1, a[6:0]} * {1'b1, b[6:0]};
		e      = $signed({3'b000, a[14:7]}) + $signed({3'b000, b[14:7]}) - 11'sd127;
		frac   = {p[13:0], 9'b0};
		if (p[15]) begin
			e    = e + 11'sd1;
			frac = {p[14:0], 8'b0};
		end
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			r = QNAN;
		end else if (a_inf || b_inf) begin
			r = {s, 8'hFF, 23'b0};
		end else if (a_zero || b_zero) begin
			r = {s, 31'b0};
		end else if (e >= 11'sd255) begin
			r = {s, 8'hFF, 23'b0};
		end else if (e <= 11'sd0) begin
			r = {s, 31'b0};
		end else begin
			r = {s, e[7:0], frac};
		end
		return r;
	endfunction

	// First half of an FP32 add: order operands, align and add the mantissas.
	function automatic align_t fadd_align(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] big, sml;
		logic [7:0]  eb, es, d;
		logic [26:0] mbig, msml, shifted;
		logic        sticky, a_nan, b_nan, a_inf, b_inf;
		align_t      r;
		r     = '0;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb   = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		d    = eb - es;
		mbig = {(big[30:23] != 8'h00), big[22:0], 3'b000};
		msml = {(sml[30:23] != 8'h00), sml[22:0], 3'b000};
		if (d >= 8'd27) begin
			shifted = '0;
			sticky  = (msml != 27'h0);
		end else begin
			shifted = msml >> d;
			sticky  = ((msml & ((27'd1 << d) - 27'd1)) != 27'h0);
		end
		shifted = shifted | {26'b0, sticky};
		if (big[31] == sml[31]) begin
			r.mant  = {1'b0, mbig} + {1'b0, shifted};
			r.zsign = big[31];
		end else begin
			r.mant  = {1'b0, mbig} - {1'b0, shifted};
			r.zsign = 1'b0;
		end
		r.sign = big[31];
		r.exp  = {2'b00, eb};
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			r.special  = 1'b1;
			r.spec_val = QNAN;
		end else if (a_inf) begin
			r.special  = 1'b1;
			r.spec_val = a;
		end else if (b_inf) begin
			r.special  = 1'b1;
			r.spec_val = b;
		end
		return r;
	endfunction

	// Second half of an FP32 add: normalise, round to nearest even and pack.
	function automatic logic [31:0] fadd_norm(input align_t x);
		logic [9:0]  e;
		logic [4:0]  lz, sh;
		logic [26:0] n;
		logic [7:0]  ef;
		logic [30:0] mag;
		logic        up;
		logic [31:0] r;
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (x.mant[i]) begin
				lz = 5'(26 - i);
			end
		end
		if (x.mant[27]) begin
			n = x.mant[27:1] | {26'b0, x.mant[0]};
			e = x.exp + 10'd1;
		end else begin
			if ((x.exp - 10'd1) < {5'b0, lz}) begin
				sh = 5'(x.exp - 10'd1);
			end else begin
				sh = lz;
			end
			n = x.mant[26:0] << sh;
			e = x.exp - {5'b0, sh};
		end
		ef  = n[26] ? e[7:0] : 8'h00;
		up  = n[2] & (n[1] | n[0] | n[3]);
		mag = {ef, n[25:3]} + {30'b0, up};
		if (x.special) begin
			r = x.spec_val;
		end else if (x.mant == 28'h0) begin
			r = {x.zsign, 31'b0};
		end else if (e >= 10'd255) begin
			r = {x.sign, 8'hFF, 23'b0};
		end else begin
			r = {x.sign, mag};
		end
		return r;
	endfunction

endpackage

/* rtl/bdp_fifo.sv */
module bdp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage for the waiting transfers.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

/* rtl/bdp_front.sv */
module bdp_front #(
	parameter int MAX_FEATURES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bdp_pkg::item_t  item,
	input  logic            push,
	input  logic            q_full,
	output logic            q_push,
	output bdp_pkg::entry_t q_entry
);
	import bdp_pkg::*;

	localparam int FT_W = $clog2(2 * MAX_FEATURES);
	localparam int BW_W = $clog2(FT_W + 1);
	localparam logic [FT_W-1:0] LIMIT = FT_W'(2 * MAX_FEATURES - 1);

	logic [LANE_W-1:0] pos_q;
	logic              wrapped_q;
	logic [FT_W-1:0]   total_q, total_d;
	logic [14:0]       lx_q, lw_q, lx_d, lw_d;
	logic              unsafe_q, unsafe_d;
	logic [1:0]        rc;
	logic [15:0]       xe, xo, we, wo;
	logic [FT_W:0]     total_sum;
	logic [BW_W-1:0]   bw;
	logic              accept;

	function automatic logic bad_code(input logic [15:0] c);
		return (c[14:0] != 15'h0) && ((c[14:0] < SUBNORM_LIMIT) || (c[14:0] > FINITE_LIMIT));
	endfunction

	function automatic logic [14:0] max15(input logic [14:0] a, input logic [14:0] b);
		return (a > b) ? a : b;
	endfunction

	assign accept = push && !q_full;
	assign q_push = accept;

	// Classify the pair: clear absent features and update the running screens.
	always_comb begin
		rc        = (item.real_count == 2'd3) ? 2'd2 : item.real_count;
		xe        = (rc != 2'd0) ? item.x_even : 16'h0;
		we        = (rc != 2'd0) ? item.w_even : 16'h0;
		xo        = (rc == 2'd2) ? item.x_odd : 16'h0;
		wo        = (rc == 2'd2) ? item.w_odd : 16'h0;
		lx_d      = max15(lx_q, max15(xe[14:0], xo[14:0]));
		lw_d      = max15(lw_q, max15(we[14:0], wo[14:0]));
		unsafe_d  = unsafe_q || bad_code(xe) || bad_code(xo) || bad_code(we) || bad_code(wo);
		total_sum = {1'b0, total_q} + (FT_W + 1)'(rc);
		total_d   = (total_sum > {1'b0, LIMIT}) ? LIMIT : total_sum[FT_W-1:0];
		bw        = '0;
		for (int i = 0; i < FT_W; i++) begin
			if (total_d[i]) begin
				bw = BW_W'(i + 1);
			end
		end
		q_entry.xe                 = xe;
		q_entry.xo                 = xo;
		q_entry.we                 = we;
		q_entry.wo                 = wo;
		q_entry.meta.lane          = pos_q;
		q_entry.meta.wrapped       = wrapped_q;
		q_entry.meta.last          = item.last_pair;
		q_entry.meta.flags.unsafe  = unsafe_d;
		q_entry.meta.flags.ovf     = ({2'b00, lx_d[14:7]} + {2'b00, lw_d[14:7]} + 10'(bw))
			>= OVF_BOUND;
	end

	// Running state of the current dot product, cleared after its last pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			total_q   <= '0;
			lx_q      <= '0;
			lw_q      <= '0;
			unsafe_q  <= 1'b0;
		end else if (accept) begin
			if (item.last_pair) begin
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				total_q   <= '0;
				lx_q      <= '0;
				lw_q      <= '0;
				unsafe_q  <= 1'b0;
			end else begin
				pos_q     <= pos_q + 1'b1;
				wrapped_q <= wrapped_q || (pos_q == LANE_W'(LANES - 1));
				total_q   <= total_d;
				lx_q      <= lx_d;
				lw_q      <= lw_d;
				unsafe_q  <= unsafe_d;
			end
		end
	end
endmodule

/* rtl/bdp_lane.sv */
module bdp_lane (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            q_empty,
	input  bdp_pkg::entry_t q_data,
	output logic            q_pop,
	output logic            snap_v,
	output logic [31:0]     snap_lanes [bdp_pkg::LANES],
	output bdp_pkg::flags_t snap_flags
);
	import bdp_pkg::*;

	logic [31:0] lanes_q [LANES];
	logic        s1_v, s2_v, s3_v, s4_v, s5_v;
	entry_t      e_s1;
	logic [31:0] po_s2, pe_s2, pe_s3, pe_s4, acc_s4;
	align_t      a1_s3, a2_s5;
	meta_t       meta_s2, meta_s3, meta_s4, meta_s5;
	logic [31:0] acc2, sum5;

	assign q_pop = en && !q_empty;

	// A lane not yet used in this dot product starts from zero.
	assign acc2 = meta_s2.wrapped ? lanes_q[meta_s2.lane] : 32'h0;
	assign sum5 = flush32(fadd_norm(a2_s5));

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			s2_v   <= 1'b0;
			s3_v   <= 1'b0;
			s4_v   <= 1'b0;
			s5_v   <= 1'b0;
			snap_v <= 1'b0;
		end else if (en) begin
			s1_v   <= !q_empty;
			s2_v   <= s1_v;
			s3_v   <= s2_v;
			s4_v   <= s3_v;
			s5_v   <= s4_v;
			snap_v <= s5_v && meta_s5.last;
		end
	end

	// The products, then the odd add, then the even add; each add is split into an align half and a normalise half.
	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= q_data;
			po_s2   <= bf16_mul(e_s1.xo, e_s1.wo);
			pe_s2   <= bf16_mul(e_s1.xe, e_s1.we);
			meta_s2 <= e_s1.meta;
			a1_s3   <= fadd_align(acc2, po_s2);
			pe_s3   <= pe_s2;
			meta_s3 <= meta_s2;
			acc_s4  <= flush32(fadd_norm(a1_s3));
			pe_s4   <= pe_s3;
			meta_s4 <= meta_s3;
			a2_s5   <= fadd_align(acc_s4, flush32(pe_s4));
			meta_s5 <= meta_s4;
		end
	end

	// Lane write-back and, on the last pair, a copy of all lanes for the reduction.
	always_ff @(posedge clk) begin
		if (en && s5_v) begin
			lanes_q[meta_s5.lane] <= sum5;
		end
		if (en) begin
			snap_flags <= meta_s5.flags;
			for (int i = 0; i < LANES; i++) begin
				if (LANE_W'(i) == meta_s5.lane) begin
					snap_lanes[i] <= sum5;
				end else if (meta_s5.wrapped || (LANE_W'(i) < meta_s5.lane)) begin
					snap_lanes[i] <= lanes_q[i];
				end else begin
					snap_lanes[i] <= 32'h0;
				end
			end
		end
	end
endmodule

/* rtl/bdp_reduce.sv */
module bdp_reduce (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             snap_v,
	input  logic [31:0]      snap_lanes [bdp_pkg::LANES],
	input  bdp_pkg::flags_t  snap_flags,
	output logic             res_v,
	output bdp_pkg::result_t res
);
	import bdp_pkg::*;

	logic [7:0]  v_q;
	flags_t      fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7, fl_s8;
	align_t      l1a_s1 [8];
	logic [31:0] l1b_s2 [8];
	align_t      l2a_s3 [4];
	logic [31:0] l2b_s4 [4];
	align_t      l3a_s5 [2];
	logic [31:0] l3b_s6 [2];
	align_t      l4a_s7;
	logic [31:0] sum_s8;
	logic [31:0] rounded;
	cause_t      cause;

	assign res_v = v_q[7];

	// Valid bits of the eight tree stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[6:0], snap_v};
		end
	end

	// Fixed tree: lane i with i+8, then i+4, then i+2, then i+1.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				l1a_s1[i] <= fadd_align(snap_lanes[i], snap_lanes[i + 8]);
				l1b_s2[i] <= fadd_norm(l1a_s1[i]);
			end
			for (int i = 0; i < 4; i++) begin
				l2a_s3[i] <= fadd_align(l1b_s2[i], l1b_s2[i + 4]);
				l2b_s4[i] <= fadd_norm(l2a_s3[i]);
			end
			for (int i = 0; i < 2; i++) begin
				l3a_s5[i] <= fadd_align(l2b_s4[i], l2b_s4[i + 2]);
				l3b_s6[i] <= fadd_norm(l3a_s5[i]);
			end
			l4a_s7 <= fadd_align(l3b_s6[0], l3b_s6[1]);
			sum_s8 <= fadd_norm(l4a_s7);
			fl_s1  <= snap_flags;
			fl_s2  <= fl_s1;
			fl_s3  <= fl_s2;
			fl_s4  <= fl_s3;
			fl_s5  <= fl_s4;
			fl_s6  <= fl_s5;
			fl_s7  <= fl_s6;
			fl_s8  <= fl_s7;
		end
	end

	// Screens in priority order, then rounding of the sum to BF16.
	always_comb begin
		rounded = sum_s8 + RNE_BIAS + {31'b0, sum_s8[16]};
		if (fl_s8.unsafe) begin
			cause = CAUSE_UNSAFE;
		end else if (fl_s8.ovf) begin
			cause = CAUSE_OVERFLOW;
		end else if ((sum_s8[30:23] == 8'hFF) || (sum_s8[30:0] < RANGE_LIMIT)) begin
			cause = CAUSE_RANGE;
		end else begin
			cause = CAUSE_NONE;
		end
		res.fallback_cause = cause;
		res.native_ok      = (cause == CAUSE_NONE);
		res.result_code    = (cause == CAUSE_NONE) ? rounded[31:16] : 16'h0;
	end
endmodule

/* rtl/bf16_dot_product_with_safety_screen.sv */
// BF16 dot product with FP32 lane accumulation and a safety screen.
// Input channel: present a pair on item and raise push; the transfer happens
// on a rising edge with push high and full low. A dot product is any run of
// pairs ending with one whose last_pair is set; its features rotate over 16
// FP32 lanes.
// Result channel: while empty is low the oldest result is on result; raise pop
// to take it. Exactly one result is produced per dot product, on its last pair.
// Throughput: one pair per cycle, including back-to-back short dot products,
// while the back pipeline is not stopped by a full result queue. A last pair
// passes the input queue, five lane stages (product, two adds split in halves),
// the lane copy and the eight-stage adder tree before its result is queued.
// When pop is held low the result queue fills, the back pipeline stops, and
// the four-entry input queue then raises full; nothing is dropped.
// Reset clears the queues, the pipeline valid bits and all running state;
// the block can take a pair as soon as reset is released.
module bf16_dot_product_with_safety_screen #(
	parameter int MAX_FEATURES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bdp_pkg::item_t   item,
	input  logic             push,
	output logic             full,
	output bdp_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);
	import bdp_pkg::*;

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;

	logic        q_push, q_full, q_empty, q_pop;
	entry_t      q_in, q_out;
	logic        en;
	logic        snap_v;
	logic [31:0] snap_lanes [LANES];
	flags_t      snap_flags;
	logic        res_v, out_full;
	result_t     res;

	assign full = q_full;

	// Back pipeline halts only when a result is ready and the output queue is full.
	assign en = !(res_v && out_full);

	bdp_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.push    (push),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_in)
	);

	bdp_fifo #(.WIDTH($bits(entry_t)), .DEPTH(IQ_DEPTH)) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_in),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_out),
		.empty  (q_empty)
	);

	bdp_lane u_lane (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.q_empty    (q_empty),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.snap_v     (snap_v),
		.snap_lanes (snap_lanes),
		.snap_flags (snap_flags)
	);

	bdp_reduce u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.snap_v     (snap_v),
		.snap_lanes (snap_lanes),
		.snap_flags (snap_flags),
		.res_v      (res_v),
		.res        (res)
	);

	bdp_fifo #(.WIDTH($bits(result_t)), .DEPTH(OQ_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_v),
		.wdata  (res),
		.full   (out_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);
endmodule

/* rtl/bdp_checker.sv */
`include "bf16_dot_product_with_safety_screen_macros.svh"

module bdp_checker (
	input logic             clk,
	input logic             arst_n,
	input bdp_pkg::item_t   item,
	input logic             push,
	input logic             full,
	input bdp_pkg::result_t result,
	input logic             empty,
	input logic             pop
);
	import bdp_pkg::*;

	// A native result never carries a fallback cause.
	`BDP_IMPLIES(a_native_clean, (!empty && result.native_ok), (result.fallback_cause == CAUSE_NONE), "native result with a fallback cause")

	// A fallback result has a cause and a zero code.
	`BDP_IMPLIES(a_fallback_zero, (!empty && !result.native_ok), ((result.result_code == 16'h0000) && (result.fallback_cause != CAUSE_NONE)), "fallback result malformed")

	// A waiting result that is not taken stays in place.
	`BDP_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")
endmodule

bind bf16_dot_product_with_safety_screen bdp_checker u_bdp_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import bdp_pkg::*;

	// A pending pair, optionally held back until every expected result has come.
	typedef struct {
		item_t pair;
		bit    hold;
	} stim_t;

	logic    clk = 1'b0;
	logic    arst_n;
	item_t   item;
	logic    push;
	logic    full;
	result_t res_bus;
	logic    empty;
	logic    pop;

	stim_t   stim_q[$];
	result_t dot_results_q[$];
	int      errors = 0;
	int      pairs_queued;
	int      sent_count = 0;
	int      taken_count = 0;
	int      send_gap;
	int      pop_gap;

	// Predictor state of the running dot product.
	logic [31:0] lane_acc[16] = '{default: '0};
	logic [3:0]  lane_ptr = '0;
	logic [16:0] feat_count = '0;
	logic [14:0] peak_x = '0;
	logic [14:0] peak_w = '0;
	logic        bad_operand = 1'b0;

	bf16_dot_product_with_safety_screen dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.push  (push),
		.full  (full),
		.result(res_bus),
		.empty (empty),
		.pop   (pop)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Subnormal values become zero of the same sign.
	function automatic logic [31:0] ftz(input logic [31:0] v);
		return (v[30:23] == 8'h00) ? {v[31], 31'b0} : v;
	endfunction

	// Exact FP32 product of two BF16 codes, subnormal operands read as zero.
	function automatic logic [31:0] bf16_product(input logic [15:0] a, input logic [15:0] b);
		logic        s;
		logic        az, bz, ai, bi, an, bn;
		logic [15:0] m;
		int          e;
		logic [22:0] frac;
		s  = a[15] ^ b[15];
		az = a[14:7] == 8'h00;
		bz = b[14:7] == 8'h00;
		ai = a[14:7] == 8'hFF && a[6:0] == 7'h00;
		bi = b[14:7] == 8'hFF && b[6:0] == 7'h00;
		an = a[14:7] == 8'hFF && a[6:0] != 7'h00;
		bn = b[14:7] == 8'hFF && b[6:0] != 7'h00;
		if (an || bn || (ai && bz) || (bi && az))
			return 32'h7FC0_0000;
		if (ai || bi)
			return {s, 8'hFF, 23'b0};
		if (az || bz)
			return {s, 31'b0};
		m = {1'b1, a[6:0]} * {1'b1, b[6:0]};
		e = int'(a[14:7]) + int'(b[14:7]) - 127;
		if (m[15]) begin
			e++;
			frac = {m[14:0], 8'b0};
		end else begin
			frac = {m[13:0], 9'b0};
		end
		if (e >= 255)
			return {s, 8'hFF, 23'b0};
		if (e <= 0)
			return {s, 31'b0};
		return {s, 8'(e), frac};
	endfunction

	// IEEE single add with round to nearest even, subnormals kept.
	function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] hi, lo;
		logic [26:0] mh, ml, al;
		logic [27:0] acc;
		logic [30:0] mag;
		logic        an, bn, ai, bi, sticky, up;
		int          eh, el, d, e;
		an = a[30:23] == 8'hFF && a[22:0] != 0;
		bn = b[30:23] == 8'hFF && b[22:0] != 0;
		ai = a[30:23] == 8'hFF && a[22:0] == 0;
		bi = b[30:23] == 8'hFF && b[22:0] == 0;
		if (an || bn || (ai && bi && a[31] != b[31]))
			return 32'h7FC0_0000;
		if (ai)
			return a;
		if (bi)
			return b;
		if (a[30:0] >= b[30:0]) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		eh = (hi[30:23] == 0) ? 1 : int'(hi[30:23]);
		el = (lo[30:23] == 0) ? 1 : int'(lo[30:23]);
		mh = {hi[30:23] != 0, hi[22:0], 3'b000};
		ml = {lo[30:23] != 0, lo[22:0], 3'b000};
		d  = eh - el;
		if (d >= 27) begin
			al     = '0;
			sticky = ml != 0;
		end else begin
			al     = ml >> d;
			sticky = (ml & ((27'd1 << d) - 27'd1)) != 0;
		end
		al[0] = al[0] | sticky;
		if (hi[31] == lo[31])
			acc = {1'b0, mh} + {1'b0, al};
		else
			acc = {1'b0, mh} - {1'b0, al};
		if (acc == 0)
			return {hi[31] & lo[31], 31'b0};
		e = eh;
		if (acc[27]) begin
			acc = (acc >> 1) | {27'b0, acc[0]};
			e++;
		end else begin
			while (!acc[26] && e > 1) begin
				acc = acc << 1;
				e--;
			end
		end
		if (e >= 255)
			return {hi[31], 8'hFF, 23'b0};
		up  = acc[2] & (acc[1] | acc[0] | acc[3]);
		mag = {(acc[26] ? 8'(e) : 8'h00), acc[25:3]} + {30'b0, up};
		return {hi[31], mag};
	endfunction

	// Largest-magnitude tracking and the unsafe-operand screen for one code.
	task automatic screen_code(input logic [15:0] c, inout logic [14:0] peak);
		if (c[14:0] > peak)
			peak = c[14:0];
		if (c[14:0] != 0 && (c[14:0] < 15'h0080 || c[14:0] > 15'h7F7F))
			bad_operand = 1'b1;
	endtask

	task automatic clear_dot();
		foreach (lane_acc[i])
			lane_acc[i] = '0;
		lane_ptr    = '0;
		feat_count  = '0;
		peak_x      = '0;
		peak_w      = '0;
		bad_operand = 1'b0;
	endtask

	// Folds one accepted pair into the running dot product; on the last pair
	// it queues the expected screened result.
	task automatic accumulate_pair(input item_t p);
		logic [15:0] xe, xo, we, wo;
		logic [1:0]  rc;
		logic [31:0] acc, tree[16];
		logic [17:0] grown;
		int          width;
		cause_t      why;
		result_t     r;
		xe = p.x_even;
		xo = p.x_odd;
		we = p.w_even;
		wo = p.w_odd;
		rc = (p.real_count > 2'd2) ? 2'd2 : p.real_count;
		if (rc < 2'd2) begin
			xo = '0;
			wo = '0;
		end
		if (rc < 2'd1) begin
			xe = '0;
			we = '0;
		end
		screen_code(xe, peak_x);
		screen_code(xo, peak_x);
		screen_code(we, peak_w);
		screen_code(wo, peak_w);
		grown      = {1'b0, feat_count} + rc;
		feat_count = (grown > 18'd131071) ? 17'd131071 : grown[16:0];

		// The lane adds the odd product first, then the even one.
		acc = ftz(lane_acc[lane_ptr]);
		acc = ftz(fp32_sum(acc, ftz(bf16_product(xo, wo))));
		acc = ftz(fp32_sum(acc, ftz(bf16_product(xe, we))));
		lane_acc[lane_ptr] = acc;
		lane_ptr++;
		if (!p.last_pair)
			return;

		// Fixed reduction tree over the sixteen lanes.
		tree = lane_acc;
		for (int i = 0; i < 8; i++)
			tree[i] = fp32_sum(tree[i], tree[i + 8]);
		for (int i = 0; i < 4; i++)
			tree[i] = fp32_sum(tree[i], tree[i + 4]);
		for (int i = 0; i < 2; i++)
			tree[i] = fp32_sum(tree[i], tree[i + 2]);
		acc = fp32_sum(tree[0], tree[1]);

		width = 0;
		for (int i = 0; i < 17; i++)
			if (feat_count[i])
				width = i + 1;
		if (bad_operand)
			why = CAUSE_UNSAFE;
		else if (int'(peak_x[14:7]) + int'(peak_w[14:7]) + width >= 380)
			why = CAUSE_OVERFLOW;
		else if (acc[30:23] == 8'hFF || acc[30:0] < 31'h0F80_0000)
			why = CAUSE_RANGE;
		else
			why = CAUSE_NONE;
		r.fallback_cause = why;
		r.native_ok      = (why == CAUSE_NONE);
		r.result_code    = '0;
		if (why == CAUSE_NONE)
			r.result_code = 16'((acc + 32'h7FFF + {31'b0, acc[16]}) >> 16);
		dot_results_q.push_back(r);
		clear_dot();
	endtask

	function automatic int idle_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45)
			return 0;
		if (k < 88)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// BF16 code drawn according to the flavour of the dot product.
	function automatic logic [15:0] draw_code(input int flavour);
		logic s;
		int   k;
		s = $urandom_range(0, 1);
		k = $urandom_range(0, 99);
		case (flavour)
			0: begin
				if (k < 12)
					return {s, 15'h0};
				return {s, 8'($urandom_range(110, 145)), 7'($urandom)};
			end
			1: begin
				if (k < 10)
					return {s, 15'h0};
				return {s, 8'($urandom_range(1, 70)), 7'($urandom)};
			end
			2: begin
				return {s, 8'($urandom_range(120, 254)), 7'($urandom)};
			end
			3: begin
				if (k < 3)
					return {s, 8'h00, 7'($urandom_range(1, 127))};
				if (k < 6)
					return {s, 8'hFF, 7'($urandom)};
				return {s, 8'($urandom_range(110, 145)), 7'($urandom)};
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic queue_pair(input logic [15:0] xe, input logic [15:0] xo,
			input logic [15:0] we, input logic [15:0] wo, input logic [1:0] rc,
			input logic last, input bit hold);
		stim_t s;
		s.pair.x_even     = xe;
		s.pair.x_odd      = xo;
		s.pair.w_even     = we;
		s.pair.w_odd      = wo;
		s.pair.real_count = rc;
		s.pair.last_pair  = last;
		s.hold            = hold;
		stim_q.push_back(s);
		pairs_queued++;
	endtask

	task automatic queue_dot(input int len, input int flavour, input bit hold);
		logic [1:0] rc;
		for (int i = 0; i < len; i++) begin
			rc = ($urandom_range(0, 9) < 8) ? 2'd2 : 2'($urandom_range(0, 3));
			queue_pair(draw_code(flavour), draw_code(flavour), draw_code(flavour),
				draw_code(flavour), rc, i == len - 1, hold && i == 0);
		end
	endtask

	// Stimulus: directed corner cases, then random dot products.
	initial begin
		int len, k;
		pairs_queued = 0;

		// One plus one, and cancellation to zero.
		queue_pair(16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80, 2'd2, 1'b1, 1'b0);
		queue_pair(16'h3F80, 16'h3F80, 16'h3F80, 16'hBF80, 2'd2, 1'b1, 1'b0);
		// Empty dot product and absent features.
		queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0, 1'b1, 1'b0);
		queue_pair(16'h4000, 16'hFFFF, 16'h4000, 16'hFFFF, 2'd1, 1'b1, 1'b0);
		// A real count of three behaves as two.
		queue_pair(16'h4040, 16'h3F80, 16'h3FC0, 16'h3F80, 2'd3, 1'b1, 1'b0);
		// Subnormal, infinity, NaN and infinity times zero are unsafe.
		queue_pair(16'h0001, 16'h3F80, 16'h3F80, 16'h3F80, 2'd2, 1'b1, 1'b0);
		queue_pair(16'h3F80, 16'h7F80, 16'h3F80, 16'h3F80, 2'd2, 1'b1, 1'b0);
		queue_pair(16'h3F80, 16'h3F80, 16'hFFC1, 16'h3F80, 2'd2, 1'b1, 1'b0);
		queue_pair(16'h7F80, 16'h3F80, 16'h0000, 16'h3F80, 2'd2, 1'b1, 1'b0);
		// Largest finite operands trip the overflow bound.
		queue_pair(16'h7F7F, 16'hFF7F, 16'h7F7F, 16'h7F7F, 2'd2, 1'b1, 1'b0);
		queue_pair(16'h7F00, 16'h3F80, 16'h3E80, 16'h3F80, 2'd2, 1'b1, 1'b0);
		// Smallest normal operands give a sum below the range floor.
		queue_pair(16'h0080, 16'h8080, 16'h0080, 16'h0080, 2'd2, 1'b1, 1'b0);
		// Rounding ties in the BF16 output, spread over all lanes.
		for (int i = 0; i < 17; i++)
			queue_pair(16'h3F81, 16'h3B80 + 16'(i), 16'h3F81, 16'h3F80,
				2'd2, i == 16, 1'b0);

		// Random dot products, mostly clean and short.
		while (pairs_queued < 1600) begin
			k = $urandom_range(0, 99);
			if (k < 80)
				len = $urandom_range(1, 24);
			else if (k < 96)
				len = $urandom_range(25, 80);
			else
				len = $urandom_range(81, 250);
			k = $urandom_range(0, 99);
			queue_dot(len, (k < 55) ? 0 : (k < 67) ? 1 : (k < 79) ? 2 : (k < 91) ? 3 : 4,
				$urandom_range(0, 99) < 4);
		end

		// A final dot product that waits for the pipeline to drain.
		queue_dot(5, 0, 1'b1);
	end

	// Reset once at the start.
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Input transfers and result transfers, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			accumulate_pair(item);
			taken_count <= taken_count + 1;
		end
		if (arst_n && pop && !empty) begin
			if (dot_results_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %h", $time, res_bus);
			end else begin
				if (res_bus.result_code !== dot_results_q[0].result_code) begin
					errors++;
					$display("%0t: result_code expected %h actual %h", $time,
						dot_results_q[0].result_code, res_bus.result_code);
				end
				if (res_bus.native_ok !== dot_results_q[0].native_ok) begin
					errors++;
					$display("%0t: native_ok expected %b actual %b", $time,
						dot_results_q[0].native_ok, res_bus.native_ok);
				end
				if (res_bus.fallback_cause !== dot_results_q[0].fallback_cause) begin
					errors++;
					$display("%0t: fallback_cause expected %0d actual %0d", $time,
						dot_results_q[0].fallback_cause, res_bus.fallback_cause);
				end
				void'(dot_results_q.pop_front());
			end
		end
	end

	// Driver: presents the next pair at the falling edge after gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			item     <= '0;
			push     <= 1'b0;
			send_gap <= 0;
		end else if (push && taken_count != sent_count) begin
			// Holding the current pair until its transfer.
		end else if (send_gap > 0) begin
			push     <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (stim_q.size() != 0 && !(stim_q[0].hold && dot_results_q.size() != 0)) begin
			item       <= stim_q[0].pair;
			push       <= 1'b1;
			sent_count <= sent_count + 1;
			send_gap   <= idle_len();
			void'(stim_q.pop_front());
		end else begin
			push <= 1'b0;
		end
	end

	// Result side: pop with random stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop     <= 1'b0;
			pop_gap <= 0;
		end else if (pop_gap > 0) begin
			pop     <= 1'b0;
			pop_gap <= pop_gap - 1;
		end else begin
			pop     <= 1'b1;
			pop_gap <= idle_len();
		end
	end

	// End of run.
	initial begin
		@(posedge arst_n);
		wait (stim_q.size() == 0 && !push);
		wait (dot_results_q.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && dot_results_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog.
	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/bdp_pkg.sv
rtl/bdp_fifo.sv
rtl/bdp_front.sv
rtl/bdp_lane.sv
rtl/bdp_reduce.sv
rtl/bf16_dot_product_with_safety_screen.sv
rtl/bdp_checker.sv
verif/testbench.sv
